[sv/lav_pkg.sv]
// Shared types, constants and arithmetic helpers of the look-at view matrix block.
package lav_pkg;

	typedef logic signed [31:0] s32_t;
	typedef logic signed [63:0] s64_t;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [2:0][31:0] eye;
		logic [2:0][31:0] up;
		logic [2:0][32:0] d;
	} item_t;

	typedef struct packed {
		logic [2:0][31:0] eye;
		logic [2:0][31:0] aux;
	} side_t;

	typedef struct packed {
		logic [2:0][29:0] m;
		logic [2:0]       neg;
		logic             zero;
		side_t            side;
	} nrm_pay_t;

	function automatic logic [5:0] msb_pos(input logic [63:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

	function automatic logic [31:0] round_sat(input s64_t v);
		logic [63:0]        m;
		logic [33:0]        q;
		logic signed [35:0] s;
		m = v[63] ? 64'(-v) : 64'(v);
		q = 34'((m + (64'd1 << 29)) >> 30);
		s = v[63] ? -$signed({2'b00, q}) : $signed({2'b00, q});
		if (s > 36'sd2147483647) return 32'h7fff_ffff;
		if (s < -36'sd2147483648) return 32'h8000_0000;
		return s[31:0];
	endfunction

endpackage

[sv/lav_front.sv]
// Input stage: takes a beat, forms eye minus target and hands the item to the queue.
module lav_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         eye_x,
	input  logic [31:0]         eye_y,
	input  logic [31:0]         eye_z,
	input  logic [31:0]         target_x,
	input  logic [31:0]         target_y,
	input  logic [31:0]         target_z,
	input  logic [31:0]         up_x,
	input  logic [31:0]         up_y,
	input  logic [31:0]         up_z,
	input  logic                q_full,
	output logic                push,
	output lav_pkg::item_t      push_item
);
	import lav_pkg::*;

	logic  vld_s1;
	item_t item_s1;
	item_t item_d;

	always_comb begin
		item_d.eye = {eye_z, eye_y, eye_x};
		item_d.up  = {up_z, up_y, up_x};
		item_d.d[0] = 33'($signed({eye_x[31], eye_x}) - $signed({target_x[31], target_x}));
		item_d.d[1] = 33'($signed({eye_y[31], eye_y}) - $signed({target_y[31], target_y}));
		item_d.d[2] = 33'($signed({eye_z[31], eye_z}) - $signed({target_z[31], target_z}));
	end

	assign in_stall  = vld_s1 && q_full;
	assign push      = vld_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

[sv/lav_fifo.sv]
// Short queue between the input stage and the matrix pipeline.
module lav_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lav_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output lav_pkg::item_t pop_item,
	output logic           not_empty
);
	import lav_pkg::*;

	item_t                mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q;
	logic [FIFO_AW-1:0]   rd_q;
	logic [FIFO_AW:0]     cnt_q;

	assign full      = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_item  = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_item;
		end
	end

endmodule

[sv/lav_norm.sv]
// Pipelined vector normalizer: scale, square root by bit steps, then division by bit steps.
module lav_norm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [2:0][63:0]      vec,
	input  lav_pkg::side_t        side_in,
	output logic                  out_valid,
	output logic [2:0][31:0]      axis,
	output lav_pkg::side_t        side_out
);
	import lav_pkg::*;

	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 31;

	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0][63:0] mag_s1, mag_s2, mag_s3;
	logic [2:0]       neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	side_t            side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [63:0]      big_s2;
	logic [5:0]       pos_s3;
	logic             zero_s3, zero_s4, zero_s5;
	logic [2:0][29:0] m_s4, m_s5;
	logic [2:0][59:0] sqr_s5;

	logic             rt_v_s [SQ_STEPS+1];
	logic [63:0]      rt_x_s [SQ_STEPS+1];
	logic [63:0]      rt_r_s [SQ_STEPS+1];
	nrm_pay_t         rt_p_s [SQ_STEPS+1];
	logic [63:0]      rt_nx  [SQ_STEPS+1];
	logic [63:0]      rt_nr  [SQ_STEPS+1];

	logic             dv_v_s [DIV_STEPS+1];
	logic [2:0][61:0] dv_r_s [DIV_STEPS+1];
	logic [2:0][30:0] dv_q_s [DIV_STEPS+1];
	logic [30:0]      dv_l_s [DIV_STEPS+1];
	nrm_pay_t         dv_p_s [DIV_STEPS+1];
	logic [2:0][61:0] dv_nr  [DIV_STEPS+1];
	logic [2:0][30:0] dv_nq  [DIV_STEPS+1];

	logic             ax_v_q;
	logic [2:0][31:0] ax_q;
	side_t            ax_side_q;

	logic [2:0][63:0] mag_d;
	logic [63:0]      big_d;
	logic [2:0][29:0] m_d;
	logic [2:0][61:0] num_d;
	logic [30:0]      len_d;
	logic [2:0][31:0] ax_d;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_d[i] = vec[i][63] ? 64'(-$signed(vec[i])) : vec[i];
		end
		big_d = mag_s1[0];
		if (mag_s1[1] > big_d) big_d = mag_s1[1];
		if (mag_s1[2] > big_d) big_d = mag_s1[2];
		for (int i = 0; i < 3; i++) begin
			if (pos_s3 >= 6'd29) m_d[i] = 30'(mag_s3[i] >> (pos_s3 - 6'd29));
			else m_d[i] = 30'(mag_s3[i] << (6'd29 - pos_s3));
		end
	end

	always_comb begin
		rt_nx[0] = '0;
		rt_nr[0] = '0;
		for (int k = 1; k <= SQ_STEPS; k++) begin
			logic [63:0] t;
			t = rt_r_s[k-1] + (64'd1 << (62 - 2 * (k - 1)));
			if (rt_x_s[k-1] >= t) begin
				rt_nx[k] = rt_x_s[k-1] - t;
				rt_nr[k] = (rt_r_s[k-1] >> 1) + (64'd1 << (62 - 2 * (k - 1)));
			end else begin
				rt_nx[k] = rt_x_s[k-1];
				rt_nr[k] = rt_r_s[k-1] >> 1;
			end
		end
	end

	always_comb begin
		len_d = rt_r_s[SQ_STEPS][30:0];
		for (int i = 0; i < 3; i++) begin
			num_d[i] = {2'b00, rt_p_s[SQ_STEPS].m[i], 30'd0} + 62'(len_d >> 1);
		end
		dv_nr[0] = '0;
		dv_nq[0] = '0;
		for (int j = 1; j <= DIV_STEPS; j++) begin
			for (int i = 0; i < 3; i++) begin
				logic [61:0] t;
				t = 62'(dv_l_s[j-1]) << (DIV_STEPS - j);
				dv_nq[j][i] = dv_q_s[j-1][i];
				if (dv_r_s[j-1][i] >= t) begin
					dv_nr[j][i] = dv_r_s[j-1][i] - t;
					dv_nq[j][i][DIV_STEPS-j] = 1'b1;
				end else begin
					dv_nr[j][i] = dv_r_s[j-1][i];
				end
			end
		end
		for (int i = 0; i < 3; i++) begin
			logic [31:0] qe;
			qe = {1'b0, dv_q_s[DIV_STEPS][i]};
			if (dv_p_s[DIV_STEPS].zero) ax_d[i] = '0;
			else if (dv_p_s[DIV_STEPS].neg[i]) ax_d[i] = 32'd0 - qe;
			else ax_d[i] = qe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int k = 0; k <= SQ_STEPS; k++) rt_v_s[k] <= 1'b0;
			for (int j = 0; j <= DIV_STEPS; j++) dv_v_s[j] <= 1'b0;
			ax_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			rt_v_s[0] <= v_s5;
			for (int k = 1; k <= SQ_STEPS; k++) rt_v_s[k] <= rt_v_s[k-1];
			dv_v_s[0] <= rt_v_s[SQ_STEPS];
			for (int j = 1; j <= DIV_STEPS; j++) dv_v_s[j] <= dv_v_s[j-1];
			ax_v_q <= dv_v_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) neg_s1[i] <= vec[i][63];
			mag_s1  <= mag_d;
			side_s1 <= side_in;

			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
			big_s2  <= big_d;

			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			side_s3 <= side_s2;
			pos_s3  <= msb_pos(big_s2);
			zero_s3 <= (big_s2 == '0);

			m_s4    <= m_d;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			side_s4 <= side_s3;

			for (int i = 0; i < 3; i++) sqr_s5[i] <= 60'(m_s4[i]) * 60'(m_s4[i]);
			m_s5    <= m_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			side_s5 <= side_s4;

			rt_x_s[0] <= 64'(sqr_s5[0]) + 64'(sqr_s5[1]) + 64'(sqr_s5[2]);
			rt_r_s[0] <= '0;
			rt_p_s[0] <= '{m: m_s5, neg: neg_s5, zero: zero_s5, side: side_s5};
			for (int k = 1; k <= SQ_STEPS; k++) begin
				rt_x_s[k] <= rt_nx[k];
				rt_r_s[k] <= rt_nr[k];
				rt_p_s[k] <= rt_p_s[k-1];
			end

			dv_r_s[0] <= num_d;
			dv_q_s[0] <= '0;
			dv_l_s[0] <= len_d;
			dv_p_s[0] <= rt_p_s[SQ_STEPS];
			for (int j = 1; j <= DIV_STEPS; j++) begin
				dv_r_s[j] <= dv_nr[j];
				dv_q_s[j] <= dv_nq[j];
				dv_l_s[j] <= dv_l_s[j-1];
				dv_p_s[j] <= dv_p_s[j-1];
			end

			ax_q      <= ax_d;
			ax_side_q <= dv_p_s[DIV_STEPS].side;
		end
	end

	assign out_valid = ax_v_q;
	assign axis      = ax_q;
	assign side_out  = ax_side_q;

endmodule

[sv/lav_back.sv]
// Matrix pipeline: back axis, right axis, true-up axis and translations, with the result register.
module lav_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  lav_pkg::item_t        item,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [11:0][31:0]     res
);
	import lav_pkg::*;

	logic             en;
	logic [2:0][63:0] d_vec;
	side_t            side1_in, side1_out, side2_in, side2_out;
	logic             n1_v, n2_v;
	logic [2:0][31:0] za, xa;

	logic             v_c1, v_c2;
	s64_t             p_c1 [6];
	logic [2:0][31:0] eye_c1, za_c1;
	logic [2:0][63:0] c_c2;
	side_t            side_c2;

	logic             v_t1, v_t2, v_t3, v_t4, v_t5;
	s64_t             py_t1 [6];
	s64_t             px_t1 [3];
	s64_t             pz_t1 [3];
	logic [2:0][31:0] xa_t1, za_t1, eye_t1;
	logic [2:0][31:0] ya_t2, xa_t2, za_t2, eye_t2;
	s64_t             sx_t2, sz_t2;
	logic [2:0][31:0] ya_t3, xa_t3, za_t3;
	logic [31:0]      m03_t3, m23_t3;
	s64_t             pe_t3 [3];
	logic [2:0][31:0] ya_t4, xa_t4, za_t4;
	logic [31:0]      m03_t4, m23_t4;
	s64_t             sy_t4;
	logic [11:0][31:0] res_t5;

	logic             out_valid_q;
	logic [11:0][31:0] res_q;

	assign en  = !out_valid_q || !out_stall;
	assign pop = en && item_valid;

	always_comb begin
		for (int i = 0; i < 3; i++) d_vec[i] = 64'($signed(item.d[i]));
		side1_in.eye = item.eye;
		side1_in.aux = item.up;
		side2_in.eye = eye_c1;
		side2_in.aux = za_c1;
	end

	lav_norm u_norm_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (item_valid),
		.vec      (d_vec),
		.side_in  (side1_in),
		.out_valid(n1_v),
		.axis     (za),
		.side_out (side1_out)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			p_c1[0] <= $signed(side1_out.aux[1]) * $signed(za[2]);
			p_c1[1] <= $signed(side1_out.aux[2]) * $signed(za[1]);
			p_c1[2] <= $signed(side1_out.aux[2]) * $signed(za[0]);
			p_c1[3] <= $signed(side1_out.aux[0]) * $signed(za[2]);
			p_c1[4] <= $signed(side1_out.aux[0]) * $signed(za[1]);
			p_c1[5] <= $signed(side1_out.aux[1]) * $signed(za[0]);
			eye_c1  <= side1_out.eye;
			za_c1   <= za;

			c_c2[0] <= p_c1[0] - p_c1[1];
			c_c2[1] <= p_c1[2] - p_c1[3];
			c_c2[2] <= p_c1[4] - p_c1[5];
			side_c2 <= side2_in;
		end
	end

	lav_norm u_norm_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_c2),
		.vec      (c_c2),
		.side_in  (side_c2),
		.out_valid(n2_v),
		.axis     (xa),
		.side_out (side2_out)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			py_t1[0] <= $signed(side2_out.aux[1]) * $signed(xa[2]);
			py_t1[1] <= $signed(side2_out.aux[2]) * $signed(xa[1]);
			py_t1[2] <= $signed(side2_out.aux[2]) * $signed(xa[0]);
			py_t1[3] <= $signed(side2_out.aux[0]) * $signed(xa[2]);
			py_t1[4] <= $signed(side2_out.aux[0]) * $signed(xa[1]);
			py_t1[5] <= $signed(side2_out.aux[1]) * $signed(xa[0]);
			for (int i = 0; i < 3; i++) begin
				px_t1[i] <= $signed(xa[i]) * $signed(side2_out.eye[i]);
				pz_t1[i] <= $signed(side2_out.aux[i]) * $signed(side2_out.eye[i]);
			end
			xa_t1  <= xa;
			za_t1  <= side2_out.aux;
			eye_t1 <= side2_out.eye;

			ya_t2[0] <= round_sat(py_t1[0] - py_t1[1]);
			ya_t2[1] <= round_sat(py_t1[2] - py_t1[3]);
			ya_t2[2] <= round_sat(py_t1[4] - py_t1[5]);
			sx_t2    <= 64'sd0 - px_t1[0] - px_t1[1] - px_t1[2];
			sz_t2    <= 64'sd0 - pz_t1[0] - pz_t1[1] - pz_t1[2];
			xa_t2    <= xa_t1;
			za_t2    <= za_t1;
			eye_t2   <= eye_t1;

			m03_t3 <= round_sat(sx_t2);
			m23_t3 <= round_sat(sz_t2);
			for (int i = 0; i < 3; i++) pe_t3[i] <= $signed(ya_t2[i]) * $signed(eye_t2[i]);
			ya_t3  <= ya_t2;
			xa_t3  <= xa_t2;
			za_t3  <= za_t2;

			sy_t4  <= 64'sd0 - pe_t3[0] - pe_t3[1] - pe_t3[2];
			ya_t4  <= ya_t3;
			xa_t4  <= xa_t3;
			za_t4  <= za_t3;
			m03_t4 <= m03_t3;
			m23_t4 <= m23_t3;

			res_t5 <= {m23_t4, za_t4[2], za_t4[1], za_t4[0],
				round_sat(sy_t4), ya_t4[2], ya_t4[1], ya_t4[0],
				m03_t4, xa_t4[2], xa_t4[1], xa_t4[0]};

			res_q <= res_t5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c1        <= 1'b0;
			v_c2        <= 1'b0;
			v_t1        <= 1'b0;
			v_t2        <= 1'b0;
			v_t3        <= 1'b0;
			v_t4        <= 1'b0;
			v_t5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_c1        <= n1_v;
			v_c2        <= v_c1;
			v_t1        <= n2_v;
			v_t2        <= v_t1;
			v_t3        <= v_t2;
			v_t4        <= v_t3;
			v_t5        <= v_t4;
			out_valid_q <= v_t5;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

[sv/look_at_view_matrix.sv]
// Top level of the look-at view matrix block.
// Takes one beat of eye, target and up (signed Q16.16) per cycle while in_stall is low and
// returns the top three rows of the right-handed view matrix: rotation rows in Q2.30 and
// saturated translations in the input format. The block is fully pipelined and sustains
// one beat per cycle while the output is not stalled. The two normalizers set most of the
// latency; each runs a 32-step square root and a 31-step division as pipeline stages. A
// four-entry queue separates the input stage from the matrix pipeline, and the whole matrix
// pipeline holds while a finished result is stalled on the output.
module look_at_view_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] m00,
	output logic signed [31:0] m01,
	output logic signed [31:0] m02,
	output logic signed [31:0] m03,
	output logic signed [31:0] m10,
	output logic signed [31:0] m11,
	output logic signed [31:0] m12,
	output logic signed [31:0] m13,
	output logic signed [31:0] m20,
	output logic signed [31:0] m21,
	output logic signed [31:0] m22,
	output logic signed [31:0] m23
);
	import lav_pkg::*;

	logic             q_full, push, pop, q_valid;
	item_t            push_item, pop_item;
	logic [11:0][31:0] res;

	lav_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.eye_x    (eye_x),
		.eye_y    (eye_y),
		.eye_z    (eye_z),
		.target_x (target_x),
		.target_y (target_y),
		.target_z (target_z),
		.up_x     (up_x),
		.up_y     (up_y),
		.up_z     (up_z),
		.q_full   (q_full),
		.push     (push),
		.push_item(push_item)
	);

	lav_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (pop),
		.pop_item (pop_item),
		.not_empty(q_valid)
	);

	lav_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(q_valid),
		.item      (pop_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign m00 = res[0];
	assign m01 = res[1];
	assign m02 = res[2];
	assign m03 = res[3];
	assign m10 = res[4];
	assign m11 = res[5];
	assign m12 = res[6];
	assign m13 = res[7];
	assign m20 = res[8];
	assign m21 = res[9];
	assign m22 = res[10];
	assign m23 = res[11];

endmodule
